>>> rtl/ais_pkg.sv
// Shared types, constants and register indexes for the alignment identity statistics block.
// Depends on nothing; every other file of the block imports it.
package ais_pkg;

  // Default capacity in columns of one alignment.
  localparam int unsigned MAX_COLUMNS_DEF = 65536;

  // Fixed field widths.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned PEN_W   = 4;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned HUND_W  = 14;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned SCORE_W = 21;
  localparam int unsigned RUN_W   = 17;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_COST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_COST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SYMBOL    = 3'd4;

  // Register reset values.
  localparam logic [PEN_W-1:0]  RST_MATCH_BONUS   = 4'd2;
  localparam logic [PEN_W-1:0]  RST_MISMATCH_COST = 4'd4;
  localparam logic [PEN_W-1:0]  RST_GAP_COST      = 4'd2;
  localparam logic [THR_W-1:0]  RST_LONG_GAP_THR  = 8'd20;
  localparam logic [CHAR_W-1:0] RST_GAP_SYMBOL    = 8'd45;

  // Identities are scaled to hundredths of a percent.
  localparam logic [HUND_W-1:0] SCALE = 14'd10000;

  // Column queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Open gap run kinds.
  localparam logic [1:0] RUN_NONE   = 2'd0;
  localparam logic [1:0] RUN_QUERY  = 2'd1;
  localparam logic [1:0] RUN_TARGET = 2'd2;

  // One classified column.
  typedef struct packed {
    logic last;
    logic equal;
    logic q_gap;
    logic t_gap;
  } col_t;

  // Scoring and run settings used by the back end.
  typedef struct packed {
    logic [PEN_W-1:0] match_bonus;
    logic [PEN_W-1:0] mismatch_cost;
    logic [PEN_W-1:0] gap_cost;
    logic [THR_W-1:0] long_gap_thr;
  } cfg_t;

endpackage

>>> rtl/ais_front.sv
// Front end: classifies each incoming column and holds it in a short queue.
// Depends on ais_pkg.
module ais_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [ais_pkg::CHAR_W-1:0]   query_char_i,
  input  logic [ais_pkg::CHAR_W-1:0]   target_char_i,
  input  logic                         last_column_i,
  input  logic [ais_pkg::CHAR_W-1:0]   gap_symbol_i,
  output logic                         col_valid_o,
  output ais_pkg::col_t                col_o,
  input  logic                         col_pop_i
);
  import ais_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  col_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  col_t            col_in;
  logic            do_push, do_pop;

  always_comb begin
    col_in.last  = last_column_i;
    col_in.equal = (query_char_i == target_char_i);
    col_in.q_gap = (query_char_i == gap_symbol_i);
    col_in.t_gap = (target_char_i == gap_symbol_i);
  end

  assign full_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign col_valid_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = col_pop_i && col_valid_o;
  assign col_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= col_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/ais_div.sv
// Iterative restoring divider, one quotient bit per cycle, for quotients below 2**HUND_W.
// Depends on ais_pkg.
module ais_div #(
  parameter int unsigned DenW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DenW+ais_pkg::HUND_W-1:0] num_i,
  input  logic [DenW-1:0]               den_i,
  output logic                          done_o,
  output logic [ais_pkg::HUND_W-1:0]    quot_o
);
  import ais_pkg::*;

  localparam int unsigned NumW  = DenW + HUND_W;
  localparam int unsigned StepW = $clog2(HUND_W + 1);

  logic [NumW-1:0]   rem_q, dsr_q;
  logic [HUND_W-1:0] quot_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q, done_q;
  logic              fits;

  assign fits   = (rem_q >= dsr_q);
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsr_q  <= {1'b0, den_i, (HUND_W - 1)'(0)};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q  <= dsr_q >> 1;
      quot_q <= {quot_q[HUND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(HUND_W);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ais_back.sv
// Back end: accumulates the statistics of classified columns, finishes an alignment
// with two divisions on a shared divider, and holds the result for the consumer.
// Depends on ais_pkg and ais_div.
module ais_back #(
  parameter int unsigned MaxColumns = ais_pkg::MAX_COLUMNS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ais_pkg::cfg_t                      cfg_i,
  input  logic                               col_valid_i,
  input  ais_pkg::col_t                      col_i,
  output logic                               col_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [ais_pkg::HUND_W-1:0]         identity_hundredths_o,
  output logic [ais_pkg::DIST_W-1:0]         mismatch_distance_o,
  output logic signed [ais_pkg::SCORE_W-1:0] alignment_score_o,
  output logic [ais_pkg::HUND_W-1:0]         effective_identity_hundredths_o
);
  import ais_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxColumns + 1);
  localparam int unsigned NumW  = CntW + HUND_W;
  localparam int unsigned DiffW = (CntW > DIST_W) ? CntW : DIST_W;
  localparam int unsigned SumW  = SCORE_W + 1;

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_DIV_ID = 3'd2;
  localparam logic [2:0] ST_MUL_EF = 3'd3;
  localparam logic [2:0] ST_DIV_EF = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [CntW-1:0]            cc_q, ec_q, el_q, em_q, pend_q;
  logic signed [SCORE_W-1:0]  score_q;
  logic [1:0]                 kind_q;
  logic [RUN_W-1:0]           len_q;
  logic [NumW-1:0]            num_q;
  logic [CntW-1:0]            den_q;
  logic                       start_q;
  logic [HUND_W-1:0]          ident_q, eff_ident_q;
  logic                       out_valid_q;
  logic [HUND_W-1:0]          res_ident_q, res_eff_q;
  logic [DIST_W-1:0]          res_dist_q;
  logic signed [SCORE_W-1:0]  res_score_q;

  logic                       div_done;
  logic [HUND_W-1:0]          div_quot, quot_safe;
  logic                       take, counted, is_match, both_gap, cont_q, cont_t, close_short;
  logic signed [SumW-1:0]     delta, score_sum;
  logic signed [SCORE_W-1:0]  score_sat;
  logic [CntW-1:0]            el_add;
  logic [DiffW-1:0]           dist_full;
  logic                       out_free;

  ais_div #(.DenW(CntW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign take      = (state_q == ST_RUN) && col_valid_i;
  assign col_pop_o = take;
  assign counted   = take && (cc_q < CntW'(MaxColumns));
  assign is_match  = !col_i.q_gap && !col_i.t_gap;
  assign both_gap  = col_i.q_gap && col_i.t_gap;
  assign cont_q    = (kind_q == RUN_QUERY) && col_i.q_gap;
  assign cont_t    = (kind_q == RUN_TARGET) && col_i.t_gap;
  assign close_short = (kind_q != RUN_NONE) && (len_q < RUN_W'(cfg_i.long_gap_thr));
  assign quot_safe = (den_q == '0) ? '0 : div_quot;
  assign out_free  = !out_valid_q || pop_i;
  assign dist_full = DiffW'(cc_q) - DiffW'(ec_q);

  // Score step with saturation to the signed result range.
  always_comb begin
    if (is_match && col_i.equal) begin
      delta = SumW'($signed({1'b0, cfg_i.match_bonus}));
    end else if (is_match) begin
      delta = -SumW'($signed({1'b0, cfg_i.mismatch_cost}));
    end else begin
      delta = -SumW'($signed({1'b0, cfg_i.gap_cost}));
    end
    score_sum = SumW'(score_q) + delta;
    if (score_sum[SumW-1] != score_sum[SumW-2]) begin
      score_sat = score_sum[SumW-1] ? {1'b1, (SCORE_W - 1)'(0)} : {1'b0, {(SCORE_W - 1){1'b1}}};
    end else begin
      score_sat = score_sum[SCORE_W-1:0];
    end
  end

  // Length added when a column is handled outside a continuing run.
  assign el_add = (close_short ? pend_q : '0) + CntW'(is_match);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (take && col_i.last) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE:  state_d = ST_DIV_ID;
      ST_DIV_ID: begin
        if (div_done) begin
          state_d = ST_MUL_EF;
        end
      end
      ST_MUL_EF: state_d = ST_DIV_EF;
      ST_DIV_EF: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cc_q        <= '0;
      ec_q        <= '0;
      el_q        <= '0;
      em_q        <= '0;
      pend_q      <= '0;
      score_q     <= '0;
      kind_q      <= RUN_NONE;
      len_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // The divider starts right after its operands are registered.
      start_q <= (state_q == ST_CLOSE) || (state_q == ST_MUL_EF);
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (counted) begin
            cc_q    <= cc_q + CntW'(1);
            ec_q    <= ec_q + CntW'(col_i.equal);
            score_q <= score_sat;
            if (cont_q || cont_t) begin
              if (len_q != {RUN_W{1'b1}}) begin
                len_q <= len_q + RUN_W'(1);
              end
              pend_q <= pend_q + CntW'(cont_q ? !col_i.t_gap : !col_i.q_gap);
            end else begin
              el_q <= el_q + el_add;
              em_q <= em_q + CntW'(is_match && col_i.equal);
              if (is_match || both_gap) begin
                kind_q <= RUN_NONE;
                len_q  <= '0;
                pend_q <= '0;
              end else begin
                kind_q <= col_i.q_gap ? RUN_QUERY : RUN_TARGET;
                len_q  <= RUN_W'(1);
                pend_q <= CntW'(1);
              end
            end
          end
        end
        ST_CLOSE: begin
          if (close_short) begin
            el_q <= el_q + pend_q;
          end
          kind_q  <= RUN_NONE;
          len_q   <= '0;
          pend_q  <= '0;
        end
        ST_DIV_ID: begin
          if (div_done) begin
            ident_q <= quot_safe;
          end
        end
        ST_DIV_EF: begin
          if (div_done) begin
            eff_ident_q <= quot_safe;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_ident_q <= ident_q;
            res_eff_q   <= eff_ident_q;
            res_dist_q  <= dist_full[DIST_W-1:0];
            res_score_q <= score_q;
            cc_q        <= '0;
            ec_q        <= '0;
            el_q        <= '0;
            em_q        <= '0;
            score_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Divider operands: identity in the close step, effective identity afterwards.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLOSE) begin
      num_q <= NumW'(ec_q) * NumW'(SCALE);
      den_q <= cc_q;
    end else if (state_q == ST_MUL_EF) begin
      num_q <= NumW'(em_q) * NumW'(SCALE);
      den_q <= el_q;
    end
  end

  assign empty_o                         = !out_valid_q;
  assign identity_hundredths_o           = res_ident_q;
  assign mismatch_distance_o             = res_dist_q;
  assign alignment_score_o               = res_score_q;
  assign effective_identity_hundredths_o = res_eff_q;

endmodule

>>> rtl/alignment_identity_statistics.sv
// Top level of the alignment identity statistics block: configuration registers,
// front end with column queue, and back end. Depends on ais_pkg, ais_front and ais_back.
//
//   Channel   Handshake             Transaction carries
//   -------   -------------------   -----------------------------------------------
//   columns   push_i / full_o       query_char_i, target_char_i, last_column_i
//   results   pop_i / empty_o       identity, mismatch distance, score, eff. identity
//   config    cfg_we_i (no stall)   cfg_idx_i selects register, cfg_wdata_i value
//
// Columns stream through the back end at one per cycle while it is accumulating; a
// last column then adds a close step and two divisions on the one shared bit-serial
// divider, with a multiply step between them and an output step after them.
// Reset clears all accumulators, the column queue and the result slot and loads the
// register defaults. While the back end divides, the four-entry queue keeps taking
// columns until it fills; a result waiting for pop_i holds only the back end's last step.
module alignment_identity_statistics #(
  parameter int unsigned MaxColumns = ais_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [ais_pkg::CHAR_W-1:0]          query_char_i,
  input  logic [ais_pkg::CHAR_W-1:0]          target_char_i,
  input  logic                                last_column_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic [ais_pkg::HUND_W-1:0]          identity_hundredths_o,
  output logic [ais_pkg::DIST_W-1:0]          mismatch_distance_o,
  output logic signed [ais_pkg::SCORE_W-1:0]  alignment_score_o,
  output logic [ais_pkg::HUND_W-1:0]          effective_identity_hundredths_o,
  input  logic                                cfg_we_i,
  input  logic [ais_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ais_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import ais_pkg::*;

  // Configuration registers. The user must change them only while the block is idle;
  // the block does not enforce it, and both halves read them directly.
  cfg_t              cfg_q;
  logic [CHAR_W-1:0] gap_symbol_q;

  logic col_valid, col_pop;
  col_t col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_bonus   <= RST_MATCH_BONUS;
      cfg_q.mismatch_cost <= RST_MISMATCH_COST;
      cfg_q.gap_cost      <= RST_GAP_COST;
      cfg_q.long_gap_thr  <= RST_LONG_GAP_THR;
      gap_symbol_q        <= RST_GAP_SYMBOL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATCH_BONUS:   cfg_q.match_bonus   <= cfg_wdata_i[PEN_W-1:0];
        REG_MISMATCH_COST: cfg_q.mismatch_cost <= cfg_wdata_i[PEN_W-1:0];
        REG_GAP_COST:      cfg_q.gap_cost      <= cfg_wdata_i[PEN_W-1:0];
        REG_LONG_GAP_THR:  cfg_q.long_gap_thr  <= cfg_wdata_i[THR_W-1:0];
        REG_GAP_SYMBOL:    gap_symbol_q        <= cfg_wdata_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each column against the gap symbol and queues it.
  ais_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .query_char_i (query_char_i),
    .target_char_i(target_char_i),
    .last_column_i(last_column_i),
    .gap_symbol_i (gap_symbol_q),
    .col_valid_o  (col_valid),
    .col_o        (col),
    .col_pop_i    (col_pop)
  );

  // The back end accumulates, divides on the last column and holds the result.
  ais_back #(.MaxColumns(MaxColumns)) u_back (
    .clk_i                          (clk_i),
    .rst_ni                         (rst_ni),
    .cfg_i                          (cfg_q),
    .col_valid_i                    (col_valid),
    .col_i                          (col),
    .col_pop_o                      (col_pop),
    .empty_o                        (empty_o),
    .pop_i                          (pop_i),
    .identity_hundredths_o          (identity_hundredths_o),
    .mismatch_distance_o            (mismatch_distance_o),
    .alignment_score_o              (alignment_score_o),
    .effective_identity_hundredths_o(effective_identity_hundredths_o)
  );

endmodule

>>> rtl/ais_checker.sv
// Port-level checker for the alignment identity statistics block, with its bind.
// Depends on ais_pkg and the top level alignment_identity_statistics.
module ais_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                full_o,
  input logic                                empty_o,
  input logic                                pop_i,
  input logic [ais_pkg::HUND_W-1:0]          identity_hundredths_o,
  input logic [ais_pkg::DIST_W-1:0]          mismatch_distance_o,
  input logic signed [ais_pkg::SCORE_W-1:0]  alignment_score_o,
  input logic [ais_pkg::HUND_W-1:0]          effective_identity_hundredths_o
);
  import ais_pkg::*;

  // Reset leaves no result waiting and an open input queue.
  assert property (@(posedge clk_i) !rst_ni |=> empty_o && !full_o)
    else $error("reset does not clear the queue and result slot");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(identity_hundredths_o)
      && $stable(mismatch_distance_o) && $stable(alignment_score_o)
      && $stable(effective_identity_hundredths_o))
    else $error("waiting result changed before it was taken");

  // Identities never exceed one hundred percent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> identity_hundredths_o <= SCALE)
    else $error("identity above one hundred percent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> effective_identity_hundredths_o <= SCALE)
    else $error("effective identity above one hundred percent");

endmodule

bind alignment_identity_statistics ais_checker u_ais_checker (
  .clk_i                          (clk_i),
  .rst_ni                         (rst_ni),
  .full_o                         (full_o),
  .empty_o                        (empty_o),
  .pop_i                          (pop_i),
  .identity_hundredths_o          (identity_hundredths_o),
  .mismatch_distance_o            (mismatch_distance_o),
  .alignment_score_o              (alignment_score_o),
  .effective_identity_hundredths_o(effective_identity_hundredths_o)
);
